[hdl/qtu_pkg.sv]
package qtu_pkg;

    // Table geometry
    localparam int NUM_STATES  = 16;
    localparam int NUM_ACTIONS = 4;
    localparam int ENTRIES     = NUM_STATES * NUM_ACTIONS;
    localparam int ADDR_W      = $clog2(ENTRIES);
    localparam int COL_W       = $clog2(NUM_ACTIONS + 1);   // counts reads, holds NUM_ACTIONS
    localparam int GREEDY_W    = $clog2(NUM_ACTIONS);

    // Field widths
    localparam int STATE_W   = 4;
    localparam int ACTION_W  = 2;
    localparam int REWARD_W  = 8;
    localparam int VALUE_W   = 24;
    localparam int RATE_W    = 9;
    localparam int FRAC_W    = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(256);
    localparam int VALUE_MAX = 8388607;
    localparam int VALUE_MIN = -8388608;
    localparam int ROUND_HALF = 128;

    localparam logic [RATE_W-1:0] LR_RESET  = RATE_W'(26);
    localparam logic [RATE_W-1:0] DSC_RESET = RATE_W'(128);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT      = CFG_IDX_W'(1);

    typedef struct packed {
        logic [STATE_W-1:0]         current_state;
        logic [ACTION_W-1:0]        chosen_action;
        logic signed [REWARD_W-1:0] reward;
        logic [STATE_W-1:0]         reached_state;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] new_value;
        logic [ACTION_W-1:0]       greedy_action;
        logic signed [VALUE_W-1:0] best_value;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DTERM,
        ST_TARGET,
        ST_BLEND,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic dterm;
        logic target;
        logic blend;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } sts_t;

    function automatic logic [STATE_W-1:0] wrap_state(input logic [STATE_W-1:0] v);
        logic [STATE_W-1:0] r;
        r = v;
        for (int i = 0; i < 8; i++) begin
            if (int'(r) >= NUM_STATES) begin
                r = r - STATE_W'(NUM_STATES);
            end
        end
        return r;
    endfunction

    function automatic logic [GREEDY_W-1:0] wrap_action(input logic [ACTION_W-1:0] v);
        logic [ACTION_W-1:0] r;
        r = v;
        for (int i = 0; i < 2; i++) begin
            if (int'(r) >= NUM_ACTIONS) begin
                r = r - ACTION_W'(NUM_ACTIONS);
            end
        end
        return GREEDY_W'(r);
    endfunction

    function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] r);
        return (r > RATE_ONE) ? RATE_ONE : r;
    endfunction

endpackage

[hdl/q_table_update_engine_top.sv]
// Channel  | Signals                                  | Direction | Moves
// ---------+------------------------------------------+-----------+-----------------------------
// in       | in_valid, in_stall, in_item              | in        | one experience
// out      | out_valid, out_stall, out_item           | out       | new value, greedy, row max
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data| in        | register write
//
// One transaction at a time. An experience runs from acceptance through the row
// scan and the arithmetic to its result; the next one can be taken in the cycle
// after write-back. The table has a single read port: NUM_ACTIONS row reads plus
// one read of the updated entry, then four arithmetic steps.
// Reset clears the whole table at once through per-entry valid flags; no sweep.
// A stalled result sits in the output register; the next experience runs
// meanwhile and waits only at write-back until the register frees.
module q_table_update_engine_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  qtu_pkg::in_item_t                 in_item,
    output logic                              out_valid,
    input  logic                              out_stall,
    output qtu_pkg::out_item_t                out_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [qtu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [qtu_pkg::RATE_W-1:0]        cfg_data
);
    import qtu_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer: scan the next-state row, read the old entry, blend, write back
    qtu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // table, row scan, fixed-point update and output register
    qtu_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

[hdl/qtu_ram.sv]
module qtu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/qtu_ctrl.sv]
module qtu_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  qtu_pkg::sts_t sts,
    output qtu_pkg::cmd_t cmd
);
    import qtu_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DTERM;
            end
            ST_DTERM:
            begin
                cmd.dterm  = 1'b1;
                state_next = ST_TARGET;
            end
            ST_TARGET:
            begin
                cmd.target = 1'b1;
                state_next = ST_BLEND;
            end
            ST_BLEND:
            begin
                cmd.blend  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold until the output register can take the result
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/qtu_dp.sv]
module qtu_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  qtu_pkg::cmd_t                     cmd,
    output qtu_pkg::sts_t                     sts,
    input  qtu_pkg::in_item_t                 in_item,
    output logic                              out_valid,
    input  logic                              out_stall,
    output qtu_pkg::out_item_t                out_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [qtu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [qtu_pkg::RATE_W-1:0]        cfg_data
);
    import qtu_pkg::*;

    localparam int PROD1_W = VALUE_W + RATE_W + 1;
    localparam int DTERM_W = PROD1_W - FRAC_W;
    localparam int TGT_W   = DTERM_W + 1;
    localparam int PA_W    = VALUE_W + RATE_W + 1;
    localparam int PB_W    = TGT_W + RATE_W + 1;
    localparam int SUM_W   = PB_W + 1;
    localparam int RAW_W   = SUM_W - FRAC_W;

    localparam logic signed [RAW_W-1:0] RAW_MAX = RAW_W'(VALUE_MAX);
    localparam logic signed [RAW_W-1:0] RAW_MIN = RAW_W'(VALUE_MIN);

    // configuration
    logic [RATE_W-1:0] lr_reg;
    logic [RATE_W-1:0] dsc_reg;

    // captured transaction
    logic [STATE_W-1:0]         cur_reg;
    logic [GREEDY_W-1:0]        col_reg;
    logic signed [REWARD_W-1:0] reward_reg;
    logic [STATE_W-1:0]         ns_reg;

    // scan
    logic [COL_W-1:0]    cnt_reg;
    logic                lag_vld_reg;
    logic [COL_W-1:0]    lag_cnt_reg;
    logic                rd_vld_reg;
    logic [ENTRIES-1:0]  valid_reg;

    logic signed [VALUE_W-1:0] best_reg;
    logic [GREEDY_W-1:0]       greedy_reg;
    logic signed [VALUE_W-1:0] old_reg;

    // arithmetic
    logic signed [PROD1_W-1:0] prod1_reg;
    logic signed [TGT_W-1:0]   target_reg;
    logic signed [PA_W-1:0]    pa_reg;
    logic signed [PB_W-1:0]    pb_reg;

    logic      out_valid_reg;
    out_item_t out_item_reg;

    logic [ADDR_W-1:0]         row_addr;
    logic [ADDR_W-1:0]         upd_addr;
    logic [ADDR_W-1:0]         rd_addr;
    logic [VALUE_W-1:0]        ram_q;
    logic signed [VALUE_W-1:0] rd_value;
    logic                      at_old;

    logic [RATE_W-1:0]         lr_eff;
    logic [RATE_W-1:0]         dsc_eff;
    logic [RATE_W:0]           inv_lr;
    logic signed [PROD1_W-1:0] prod1_next;
    logic signed [PROD1_W-1:0] prod1_rnd;
    logic signed [TGT_W-1:0]   target_next;
    logic signed [PA_W-1:0]    pa_next;
    logic signed [PB_W-1:0]    pb_next;
    logic signed [SUM_W-1:0]   sum;
    logic signed [RAW_W-1:0]   raw;
    logic signed [VALUE_W-1:0] new_val;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg  <= LR_RESET;
            dsc_reg <= DSC_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_LEARNING_RATE)
            begin
                lr_reg <= cfg_data;
            end
            else if (cfg_index == CFG_DISCOUNT)
            begin
                dsc_reg <= cfg_data;
            end
        end
    end

    // addressing: row entries first, then the entry being updated
    assign at_old   = (cnt_reg == COL_W'(NUM_ACTIONS));
    assign row_addr = ADDR_W'(ns_reg) * ADDR_W'(NUM_ACTIONS) + ADDR_W'(cnt_reg);
    assign upd_addr = ADDR_W'(cur_reg) * ADDR_W'(NUM_ACTIONS) + ADDR_W'(col_reg);
    assign rd_addr  = at_old ? upd_addr : row_addr;

    qtu_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.finish),
        .wr_addr (upd_addr),
        .wr_data (new_val),
        .rd_en   (cmd.scan),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // entries never written read as zero
    assign rd_value = rd_vld_reg ? $signed(ram_q) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            lag_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            lag_vld_reg <= cmd.scan;
            if (cmd.load)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.scan)
            begin
                cnt_reg <= cnt_reg + COL_W'(1);
            end
            if (cmd.finish)
            begin
                valid_reg[upd_addr] <= 1'b1;
                out_valid_reg       <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // arithmetic
    assign lr_eff      = clamp_rate(lr_reg);
    assign dsc_eff     = clamp_rate(dsc_reg);
    assign inv_lr      = {1'b0, RATE_ONE} - {1'b0, lr_eff};
    assign prod1_next  = PROD1_W'($signed({1'b0, dsc_eff})) * PROD1_W'(best_reg);
    assign prod1_rnd   = prod1_reg + PROD1_W'(ROUND_HALF);
    assign target_next = (TGT_W'(reward_reg) <<< FRAC_W)
                         + TGT_W'(DTERM_W'(prod1_rnd >>> FRAC_W));
    assign pa_next     = PA_W'($signed(inv_lr)) * PA_W'(old_reg);
    assign pb_next     = PB_W'($signed({1'b0, lr_eff})) * PB_W'(target_reg);
    assign sum         = SUM_W'(pa_reg) + SUM_W'(pb_reg) + SUM_W'(ROUND_HALF);
    assign raw         = RAW_W'(sum >>> FRAC_W);

    always_comb
    begin
        if (raw > RAW_MAX)
        begin
            new_val = VALUE_W'(VALUE_MAX);
        end
        else if (raw < RAW_MIN)
        begin
            new_val = VALUE_W'(VALUE_MIN);
        end
        else
        begin
            new_val = VALUE_W'(raw);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_reg    <= wrap_state(in_item.current_state);
            col_reg    <= wrap_action(in_item.chosen_action);
            reward_reg <= in_item.reward;
            ns_reg     <= wrap_state(in_item.reached_state);
        end
        if (cmd.scan)
        begin
            rd_vld_reg  <= valid_reg[rd_addr];
            lag_cnt_reg <= cnt_reg;
        end
        if (lag_vld_reg)
        begin
            if (lag_cnt_reg == '0)
            begin
                best_reg   <= rd_value;
                greedy_reg <= '0;
            end
            else if (lag_cnt_reg == COL_W'(NUM_ACTIONS))
            begin
                old_reg <= rd_value;
            end
            else if (rd_value > best_reg)
            begin
                best_reg   <= rd_value;
                greedy_reg <= GREEDY_W'(lag_cnt_reg);
            end
        end
        if (cmd.dterm)
        begin
            prod1_reg <= prod1_next;
        end
        if (cmd.target)
        begin
            target_reg <= target_next;
        end
        if (cmd.blend)
        begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
        end
        if (cmd.finish)
        begin
            out_item_reg.new_value     <= new_val;
            out_item_reg.greedy_action <= ACTION_W'(greedy_reg);
            out_item_reg.best_value    <= best_reg;
        end
    end

    assign sts.scan_last = at_old;
    assign sts.out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

[hdl/qtu_checker.sv]
module qtu_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input qtu_pkg::out_item_t out_item
);

    // one transaction in flight: taking one closes the input
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while a transaction is in flight");

    // a result only appears from a transaction that was in flight
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared with no transaction in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(out_item))
        else $error("out_item changed while stalled");

endmodule

bind q_table_update_engine_top qtu_checker u_qtu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
